@@ src/tea_pkg.sv @@
package tea_pkg;

  // cipher geometry
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

  // key register reset values
  localparam logic [WORD_W-1:0] KEY0_RST = 32'h0000_0004;
  localparam logic [WORD_W-1:0] KEY1_RST = 32'h0000_0003;
  localparam logic [WORD_W-1:0] KEY2_RST = 32'h0000_0002;
  localparam logic [WORD_W-1:0] KEY3_RST = 32'h0000_0001;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

  // operation codes carried in the kind bit
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  // one item travelling down the round pipeline
  typedef struct packed {
    logic  valid;
    logic  kind;
    word_t v0;
    word_t v1;
  } stage_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } result_t;

  // running sum seen by round rnd, for encryption and decryption
  function automatic word_t enc_sum(input int unsigned rnd);
    word_t n;
    n = WORD_W'(rnd + 1);
    return word_t'(DELTA * n);
  endfunction

  function automatic word_t dec_sum(input int unsigned rnd);
    word_t n;
    n = WORD_W'(ROUNDS - rnd);
    return word_t'(DELTA * n);
  endfunction

endpackage

@@ src/tea_in_if.sv @@
interface tea_in_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  word_t word_first;
  word_t word_second;

  modport source (output valid, kind, word_first, word_second, input ready);
  modport sink (input valid, kind, word_first, word_second, output ready);
endinterface

@@ src/tea_out_if.sv @@
interface tea_out_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_first;
  word_t out_second;

  modport source (output valid, out_first, out_second, input ready);
  modport sink (input valid, out_first, out_second, output ready);
endinterface

@@ src/tea_cfg_if.sv @@
interface tea_cfg_if;
  import tea_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/tea_half_stage.sv @@
module tea_half_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            second,
  input  tea_pkg::word_t  sum_enc,
  input  tea_pkg::word_t  sum_dec,
  input  tea_pkg::key_t   key,
  input  tea_pkg::stage_t d,
  output tea_pkg::stage_t q
);
  import tea_pkg::*;

  logic  upd_v0;
  word_t x;
  word_t ka;
  word_t kb;
  word_t s;
  word_t mix;
  word_t tgt;
  word_t res;

  // which half gets updated: encrypt goes v0 then v1, decrypt v1 then v0
  assign upd_v0 = ~(d.kind ^ second);
  assign x      = upd_v0 ? d.v1 : d.v0;
  assign ka     = upd_v0 ? key.k0 : key.k2;
  assign kb     = upd_v0 ? key.k1 : key.k3;
  assign s      = (d.kind == KIND_DEC) ? sum_dec : sum_enc;

  // tea mixing function
  assign mix = ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  assign tgt = upd_v0 ? d.v0 : d.v1;
  assign res = (d.kind == KIND_DEC) ? (tgt - mix) : (tgt + mix);

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.kind <= d.kind;
      q.v0   <= upd_v0 ? res : d.v0;
      q.v1   <= upd_v0 ? d.v1 : res;
    end
  end

endmodule

@@ src/tea_skid.sv @@
module tea_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tea_pkg::result_t  din,
  output logic              full,
  tea_out_if.source         res
);
  import tea_pkg::*;

  result_t    buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full           = (count == 2'd2);
  assign pop            = res.valid && res.ready;
  assign res.valid      = (count != 2'd0);
  assign res.out_first  = buf_q[rd_ptr].first;
  assign res.out_second = buf_q[rd_ptr].second;

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      buf_q[wr_ptr] <= din;
    end
  end

endmodule

@@ src/tea_block_cipher_top.sv @@
// datapath: 64 half-round stages followed by the output buffer; one block
// accepted per cycle while the output buffer has room, set by the stage chain
// throughput: one block every cycle while results are taken; a two-entry
// output buffer holds finished results, the pipeline halts only when it is full
// reset: clears stage valid bits and output buffer, key words go to 4, 3, 2, 1
module tea_block_cipher_top (
  input logic       clk,
  input logic       rst,
  tea_in_if.sink    blk,
  tea_cfg_if.sink   cfg,
  tea_out_if.source res
);
  import tea_pkg::*;

  key_t    key;
  stage_t  stg [STAGES+1];
  logic    advance;
  logic    full;
  result_t last_res;

  // key registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.k0 <= KEY0_RST;
      key.k1 <= KEY1_RST;
      key.k2 <= KEY2_RST;
      key.k3 <= KEY3_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_KEY0: key.k0 <= cfg.data;
        REG_KEY1: key.k1 <= cfg.data;
        REG_KEY2: key.k2 <= cfg.data;
        REG_KEY3: key.k3 <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output buffer has room
  assign advance   = ~full;
  assign blk.ready = advance;

  assign stg[0].valid = blk.valid;
  assign stg[0].kind  = blk.kind;
  assign stg[0].v0    = blk.word_first;
  assign stg[0].v1    = blk.word_second;

  // half-round stages, two per tea round
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam word_t SUM_E = enc_sum(i / 2);
    localparam word_t SUM_D = dec_sum(i / 2);
    localparam logic  HALF  = 1'((i % 2));

    tea_half_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .second  (HALF),
      .sum_enc (SUM_E),
      .sum_dec (SUM_D),
      .key     (key),
      .d       (stg[i]),
      .q       (stg[i+1])
    );
  end

  // output buffer
  assign last_res.first  = stg[STAGES].v0;
  assign last_res.second = stg[STAGES].v1;

  tea_skid u_skid (
    .clk  (clk),
    .rst  (rst),
    .push (advance && stg[STAGES].valid),
    .din  (last_res),
    .full (full),
    .res  (res)
  );

endmodule
